// ===== src/wildcard_mask_matcher_core_defines.svh =====
// Assertion macros shared by the wildcard mask matcher RTL.
`ifndef WILDCARD_MASK_MATCHER_CORE_DEFINES_SVH
`define WILDCARD_MASK_MATCHER_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define WMM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define WMM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/wmm_pkg.sv =====
// Package: codes, types and helpers for the wildcard mask matcher.
package wmm_pkg;

  localparam int DEF_MASK_DEPTH    = 256;
  localparam int DEF_SUBJECT_DEPTH = 256;

  localparam logic [7:0] CH_STAR     = 8'h2A;
  localparam logic [7:0] CH_PERCENT  = 8'h25;
  localparam logic [7:0] CH_QUESTION = 8'h3F;
  localparam logic [7:0] CH_QUOTE    = 8'h5C;
  localparam logic [7:0] CH_SPACE    = 8'h20;

  localparam logic [1:0] MODE_MASK = 2'd0;
  localparam logic [1:0] MODE_SUBJ = 2'd1;
  localparam logic [1:0] MODE_RUN  = 2'd2;

  localparam logic [2:0] OP_NONE  = 3'd0;
  localparam logic [2:0] OP_LOAD  = 3'd1;
  localparam logic [2:0] OP_START = 3'd2;
  localparam logic [2:0] OP_FLUSH = 3'd3;
  localparam logic [2:0] OP_READ  = 3'd4;
  localparam logic [2:0] OP_EVAL  = 3'd5;
  localparam logic [2:0] OP_PREAD = 3'd6;
  localparam logic [2:0] OP_PEVAL = 3'd7;

  localparam logic [1:0] EV_NEXT  = 2'd0;
  localparam logic [1:0] EV_PREAD = 2'd1;
  localparam logic [1:0] EV_DONE  = 2'd2;

  localparam logic [8:0] COUNT_MAX = 9'h1FF;

  typedef struct packed {
    logic [2:0] op;
  } cmd_t;

  typedef struct packed {
    logic       ovf;
    logic       out_full;
    logic [1:0] ev;
  } status_t;

  function automatic logic [7:0] fold_case(input logic [7:0] c);
    fold_case = (c >= 8'h41 && c <= 8'h5A) ? c + 8'h20 : c;
  endfunction

endpackage

// ===== src/wildcard_mask_matcher_core.sv =====
// Top level: wildcard mask matcher, controller plus datapath.
//
//  channel | signals                                  | direction
//  --------+------------------------------------------+----------
//  in      | in_valid, in_stall, mode, char_byte      | item in
//  out     | out_valid, out_stall, matched,           | item out
//          | literal_count, overflow                  |
//
// Load items (mode 0 or 1) go on while a result waits.
// Each walk step of a run item is a RAM read, then an evaluate; each percent
// retry adds a further read and evaluate. A run after overflow is answered
// by a flush, without a walk. Synchronous reset clears lengths, overflow,
// the result valid flag and the sequencer; store contents are undefined
// until written. A run item is stalled until the output register is empty;
// out_stall only holds the result register.
module wildcard_mask_matcher_core import wmm_pkg::*; #(
  parameter int MASK_DEPTH    = DEF_MASK_DEPTH,
  parameter int SUBJECT_DEPTH = DEF_SUBJECT_DEPTH
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] mode,
  input  logic [7:0] char_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       matched,
  output logic [8:0] literal_count,
  output logic       overflow
);

  cmd_t    cmd;
  status_t status;

  // Sequencer: owns the handshake and steps the walk.
  wmm_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .mode(mode),
    .in_stall(in_stall), .status(status), .cmd(cmd)
  );

  // Stores, walk state, resume points and result register.
  wmm_dp #(.MASK_DEPTH(MASK_DEPTH), .SUBJECT_DEPTH(SUBJECT_DEPTH)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .status(status),
    .mode(mode), .char_byte(char_byte),
    .out_valid(out_valid), .out_stall(out_stall), .matched(matched),
    .literal_count(literal_count), .overflow(overflow)
  );

endmodule

// ===== src/wmm_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module wmm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/wmm_dp.sv =====
// Datapath: byte stores, match walk registers and result register.
module wmm_dp import wmm_pkg::*; #(
  parameter int MASK_DEPTH    = DEF_MASK_DEPTH,
  parameter int SUBJECT_DEPTH = DEF_SUBJECT_DEPTH
) (
  input  logic       clk,
  input  logic       rst,
  input  cmd_t       cmd,
  output status_t    status,
  input  logic [1:0] mode,
  input  logic [7:0] char_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       matched,
  output logic [8:0] literal_count,
  output logic       overflow
);

`include "wildcard_mask_matcher_core_defines.svh"

  localparam int MAW = $clog2(MASK_DEPTH);
  localparam int SAW = $clog2(SUBJECT_DEPTH);
  localparam int MLW = $clog2(MASK_DEPTH + 1);
  localparam int SLW = $clog2(SUBJECT_DEPTH + 1);

  logic [MLW-1:0] mask_len, m, m_next, sm, sm_next, pm, pm_next;
  logic [MLW-1:0] count, count_next, acount, acount_next, pcount, pcount_next;
  logic [SLW-1:0] subj_len, n, n_next, sn, sn_next, pn, pn_next;
  logic           ovf, svalid, svalid_next, pvalid, pvalid_next;
  logic           saw, saw_next, quoted, quoted_next, hit;
  logic [1:0]     ev;
  logic [MLW-1:0] m_inc;
  logic [7:0]     mc, sc;
  logic           mask_we, subj_we, m_end, mismatch, star_back;

  assign mask_we = (cmd.op == OP_LOAD) && (mode == MODE_MASK) &&
                   (mask_len < MLW'(MASK_DEPTH));
  assign subj_we = (cmd.op == OP_LOAD) && (mode == MODE_SUBJ) &&
                   (subj_len < SLW'(SUBJECT_DEPTH));

  wmm_ram #(.WIDTH(8), .DEPTH(MASK_DEPTH)) u_mask_ram (
    .clk(clk), .we(mask_we), .waddr(mask_len[MAW-1:0]), .wdata(char_byte),
    .raddr(m[MAW-1:0]), .rdata(mc)
  );

  wmm_ram #(.WIDTH(8), .DEPTH(SUBJECT_DEPTH)) u_subj_ram (
    .clk(clk), .we(subj_we), .waddr(subj_len[SAW-1:0]), .wdata(char_byte),
    .raddr((cmd.op == OP_PREAD) ? pn[SAW-1:0] : n[SAW-1:0]), .rdata(sc)
  );

  assign m_inc = m + 1'b1;
  assign m_end = (m >= mask_len);

  // One walk step per evaluate; star fallback shared by both evaluates.
  always_comb begin
    m_next = m; n_next = n; count_next = count;
    sm_next = sm; sn_next = sn; svalid_next = svalid; acount_next = acount;
    pm_next = pm; pn_next = pn; pvalid_next = pvalid; pcount_next = pcount;
    saw_next = saw; quoted_next = quoted;
    ev = EV_NEXT; hit = 1'b0; mismatch = 1'b0; star_back = 1'b0;
    case (cmd.op)
      OP_EVAL: begin
        if (!quoted && !m_end && mc == CH_STAR) begin
          m_next = m_inc; sm_next = m_inc; sn_next = n; svalid_next = 1'b1;
          saw_next = 1'b1; pvalid_next = 1'b0; acount_next = count;
        end else if (!quoted && !m_end && mc == CH_PERCENT) begin
          m_next = m_inc; pm_next = m_inc; pn_next = n; pvalid_next = 1'b1;
          pcount_next = count;
        end else if (!quoted && !m_end && mc == CH_QUESTION) begin
          m_next = m_inc;
          if (n >= subj_len) ev = EV_DONE;
          else n_next = n + 1'b1;
        end else if (!quoted && !m_end && mc == CH_QUOTE) begin
          m_next = m_inc;
          if (m_inc >= mask_len) ev = EV_DONE;
          else quoted_next = 1'b1;
        end else begin
          quoted_next = 1'b0;
          if (m_end) begin
            if (n >= subj_len || saw) begin
              ev = EV_DONE; hit = 1'b1;
            end else begin
              mismatch = 1'b1;
            end
          end else begin
            saw_next = 1'b0;
            if (n < subj_len && fold_case(mc) == fold_case(sc)) begin
              m_next = m_inc; n_next = n + 1'b1; count_next = count + 1'b1;
              if (sc == CH_SPACE) pvalid_next = 1'b0;
            end else begin
              mismatch = 1'b1;
            end
          end
        end
        if (mismatch) begin
          if (n >= subj_len) ev = EV_DONE;
          else if (pvalid) ev = EV_PREAD;
          else star_back = 1'b1;
        end
      end
      OP_PEVAL: begin
        m_next = pm;
        if (sc == CH_SPACE) begin
          pvalid_next = 1'b0; star_back = 1'b1;
        end else begin
          pn_next = pn + 1'b1; n_next = pn + 1'b1; count_next = pcount;
        end
      end
      default: ;
    endcase
    if (star_back) begin
      if (!svalid) begin
        ev = EV_DONE;
      end else begin
        m_next = sm; sn_next = sn + 1'b1; n_next = sn + 1'b1;
        count_next = acount;
      end
    end
  end

  assign status.ovf      = ovf;
  assign status.out_full = out_valid;
  assign status.ev       = ev;

  always_ff @(posedge clk) begin
    if (rst) begin
      mask_len <= '0; subj_len <= '0; ovf <= 1'b0; out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall) out_valid <= 1'b0;
      if (cmd.op == OP_LOAD) begin
        if (mode == MODE_MASK) begin
          if (mask_we) mask_len <= mask_len + 1'b1;
          else ovf <= 1'b1;
        end else if (mode == MODE_SUBJ) begin
          if (subj_we) subj_len <= subj_len + 1'b1;
          else ovf <= 1'b1;
        end
      end
      if (cmd.op == OP_FLUSH ||
          ((cmd.op == OP_EVAL || cmd.op == OP_PEVAL) && ev == EV_DONE)) begin
        out_valid <= 1'b1; mask_len <= '0; subj_len <= '0; ovf <= 1'b0;
      end
    end
  end

  // Walk registers and result payload: no reset needed.
  always_ff @(posedge clk) begin
    if (cmd.op == OP_START) begin
      m <= '0; n <= '0; count <= '0; acount <= '0; pcount <= '0;
      sm <= '0; sn <= '0; pm <= '0; pn <= '0;
      svalid <= 1'b0; pvalid <= 1'b0; saw <= 1'b0; quoted <= 1'b0;
    end else begin
      m <= m_next; n <= n_next; count <= count_next;
      acount <= acount_next; pcount <= pcount_next;
      sm <= sm_next; sn <= sn_next; pm <= pm_next; pn <= pn_next;
      svalid <= svalid_next; pvalid <= pvalid_next;
      saw <= saw_next; quoted <= quoted_next;
    end
    if (cmd.op == OP_FLUSH) begin
      matched <= 1'b0; literal_count <= '0; overflow <= 1'b1;
    end else if ((cmd.op == OP_EVAL || cmd.op == OP_PEVAL) && ev == EV_DONE) begin
      matched  <= hit;
      overflow <= 1'b0;
      if (!hit) literal_count <= '0;
      else if (count > MLW'(COUNT_MAX)) literal_count <= COUNT_MAX;
      else literal_count <= 9'(count);
    end
  end

  `WMM_ASSERT_NOW(a_mask_idx, cmd.op == OP_EVAL, m <= mask_len, "mask index past length")
  `WMM_ASSERT_NOW(a_subj_idx, cmd.op == OP_EVAL, n <= subj_len, "subject index past length")
  `WMM_ASSERT_NEXT(a_clear, (cmd.op == OP_EVAL || cmd.op == OP_PEVAL) && ev == EV_DONE,
    mask_len == '0 && subj_len == '0 && !ovf && out_valid, "run did not clear")

endmodule

// ===== src/wmm_ctrl.sv =====
// Controller: input handshake and match walk sequencer.
module wmm_ctrl import wmm_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic [1:0] mode,
  output logic       in_stall,
  input  status_t    status,
  output cmd_t       cmd
);

`include "wildcard_mask_matcher_core_defines.svh"

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_READ  = 3'd1;
  localparam logic [2:0] ST_EVAL  = 3'd2;
  localparam logic [2:0] ST_PREAD = 3'd3;
  localparam logic [2:0] ST_PEVAL = 3'd4;

  logic [2:0] state, state_next;
  logic       accept;

  assign in_stall = (state != ST_IDLE) || (status.out_full && mode == MODE_RUN);
  assign accept   = in_valid && !in_stall;

  always_comb begin
    state_next = state;
    cmd.op     = OP_NONE;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          unique case (mode) inside
            MODE_MASK, MODE_SUBJ: cmd.op = OP_LOAD;
            MODE_RUN: begin
              if (status.ovf) begin
                cmd.op = OP_FLUSH;
              end else begin
                cmd.op = OP_START; state_next = ST_READ;
              end
            end
            default: ;
          endcase
        end
      end
      ST_READ: begin
        cmd.op = OP_READ; state_next = ST_EVAL;
      end
      ST_EVAL: begin
        cmd.op = OP_EVAL;
        if (status.ev == EV_DONE) state_next = ST_IDLE;
        else if (status.ev == EV_PREAD) state_next = ST_PREAD;
        else state_next = ST_READ;
      end
      ST_PREAD: begin
        cmd.op = OP_PREAD; state_next = ST_PEVAL;
      end
      ST_PEVAL: begin
        cmd.op = OP_PEVAL;
        state_next = (status.ev == EV_DONE) ? ST_IDLE : ST_READ;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  `WMM_ASSERT_NEXT(a_run_start, accept && mode == MODE_RUN && !status.ovf,
    state == ST_READ, "run did not start a walk")
  `WMM_ASSERT_NOW(a_run_room, accept && mode == MODE_RUN, !status.out_full,
    "run taken with result pending")
  `WMM_ASSERT_NOW(a_busy, state != ST_IDLE, in_stall, "item taken during walk")

endmodule

// ===== bench/tb_wildcard_mask_matcher_core.sv =====
// Self-checking bench for the wildcard mask matcher core.
module tb_wildcard_mask_matcher_core;
  import wmm_pkg::*;

  localparam int MDEPTH = DEF_MASK_DEPTH;
  localparam int SDEPTH = DEF_SUBJECT_DEPTH;
  localparam int CYCLE_LIMIT = 3000000;
  localparam int ITEM_TARGET = 1650;
  localparam logic [1:0] MODE_SPARE = 2'd3;

  logic       clk;
  logic       rst;
  logic       in_valid;
  logic       in_stall;
  logic [1:0] mode;
  logic [7:0] char_byte;
  logic       out_valid;
  logic       out_stall;
  logic       matched;
  logic [8:0] literal_count;
  logic       overflow;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] chr;
  } load_item_t;

  typedef struct packed {
    logic       matched;
    logic [8:0] count;
    logic       overflow;
  } verdict_t;

  wildcard_mask_matcher_core i_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .mode         (mode),
    .char_byte    (char_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .matched      (matched),
    .literal_count(literal_count),
    .overflow     (overflow)
  );

  // Clock: 10 time unit period.
  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Predictor state: its own copy of the stores and lengths.
  logic [7:0] mask_bytes [MDEPTH];
  logic [7:0] subj_bytes [SDEPTH];
  int         mask_len;
  int         subj_len;
  bit         ovf_seen;

  load_item_t pending_items[$];
  verdict_t   expected_verdicts[$];
  int         errors;
  int         runs_sent;
  int         hits_seen;
  int         cycles;
  int         pushed;
  bit         stim_done;
  bit         hold_sender;

  function automatic logic [7:0] lower(input logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5A) ? c + 8'h20 : c;
  endfunction

  // Bounded greedy backtrack: one star and one percent resume point.
  // Returns -1 on no match, else literal count.
  function automatic int walk_match();
    int  m, n, cnt, acnt, pcnt;
    int  sm, sn, pm, pn;
    bit  sv, pv, star_last, miss, via_star, m_end;
    logic [7:0] mc;
    m = 0; n = 0; cnt = 0; acnt = 0; pcnt = 0;
    sm = 0; sn = 0; pm = 0; pn = 0;
    sv = 0; pv = 0; star_last = 0;
    forever begin
      m_end = (m >= mask_len);
      mc = m_end ? 8'h00 : mask_bytes[m];
      miss = 0;
      if (!m_end && mc == CH_STAR) begin
        m++; sm = m; sn = n; sv = 1; star_last = 1; pv = 0; acnt = cnt;
        continue;
      end
      if (!m_end && mc == CH_PERCENT) begin
        m++; pm = m; pn = n; pv = 1; pcnt = cnt;
        continue;
      end
      if (!m_end && mc == CH_QUESTION) begin
        m++;
        if (n >= subj_len) return -1;
        n++;
        continue;
      end
      if (!m_end && mc == CH_QUOTE) begin
        m++;
        if (m >= mask_len) return -1;
      end
      if (m >= mask_len) begin
        if (n >= subj_len) return cnt;
        if (star_last) return cnt;
        miss = 1;
      end else begin
        star_last = 0;
        if (n < subj_len && lower(mask_bytes[m]) == lower(subj_bytes[n])) begin
          m++;
          if (subj_bytes[n] == CH_SPACE) pv = 0;
          cnt++; n++;
        end else begin
          miss = 1;
        end
      end
      if (miss) begin
        via_star = 0;
        if (n >= subj_len) return -1;
        if (pv) begin
          m = pm;
          // pn < subj_len always holds here since pn <= n
          if (subj_bytes[pn] == CH_SPACE) begin
            pv = 0; via_star = 1;
          end else begin
            pn++; n = pn; cnt = pcnt;
          end
        end else begin
          via_star = 1;
        end
        if (via_star) begin
          if (!sv) return -1;
          m = sm; sn++; n = sn; cnt = acnt;
        end
      end
    end
  endfunction

  // Applies one accepted item to the predictor.
  function automatic void predict_item(input load_item_t it);
    int r;
    verdict_t v;
    case (it.mode)
      MODE_MASK: begin
        if (mask_len < MDEPTH) begin mask_bytes[mask_len] = it.chr; mask_len++; end
        else ovf_seen = 1;
      end
      MODE_SUBJ: begin
        if (subj_len < SDEPTH) begin subj_bytes[subj_len] = it.chr; subj_len++; end
        else ovf_seen = 1;
      end
      MODE_RUN: begin
        r = ovf_seen ? -1 : walk_match();
        v.matched  = (r >= 0);
        v.count    = (r < 0) ? 9'd0 : (r > 511) ? COUNT_MAX : r[8:0];
        v.overflow = ovf_seen;
        expected_verdicts.push_back(v);
        mask_len = 0; subj_len = 0; ovf_seen = 0;
      end
      default: ;
    endcase
  endfunction

  // Stimulus helpers: push whole strings into the pending queue.
  task automatic push(input logic [1:0] md, input logic [7:0] c);
    load_item_t it;
    it.mode = md;
    it.chr  = c;
    pending_items.push_back(it);
    pushed++;
  endtask

  task automatic push_str(input logic [1:0] md, input string s);
    for (int i = 0; i < s.len(); i++) push(md, s[i]);
  endtask

  task automatic push_case(input string msk, input string sub);
    push_str(MODE_MASK, msk);
    push_str(MODE_SUBJ, sub);
    push(MODE_RUN, 8'($urandom));
  endtask

  // Random byte, biased towards metacharacters and a small alphabet so
  // that matches actually happen.
  function automatic logic [7:0] pick_byte(input bit for_mask);
    int sel;
    sel = $urandom_range(0, 19);
    if (for_mask && sel == 0) return CH_STAR;
    if (for_mask && sel == 1) return CH_PERCENT;
    if (for_mask && sel == 2) return CH_QUESTION;
    if (for_mask && sel == 3) return CH_QUOTE;
    if (sel == 4) return CH_SPACE;
    if (sel == 5) return 8'($urandom_range(0, 255));
    if (sel < 12) return 8'(8'h61 + $urandom_range(0, 2));
    return 8'(8'h41 + $urandom_range(0, 2));
  endfunction

  // Initial block: reset, then fill the pending queue.
  initial begin
    int len_m, len_s, pick;
    string subj;
    rst = 1'b1;
    errors = 0; runs_sent = 0; hits_seen = 0; stim_done = 0; hold_sender = 0;
    mask_len = 0; subj_len = 0; ovf_seen = 0; pushed = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed part: empty run, each metacharacter, quoting, case fold.
    push(MODE_RUN, 8'h00);
    push_case("a*C", "AbbC");
    push_case("%d", "abd");
    push_case("%d", "a d");
    push_case("\\*", "*");
    push_case("ab\\", "ab");
    push_case("?", "");
    push(MODE_SPARE, 8'hFF);           // unused mode: ignored
    push(MODE_MASK, 8'h00);
    push(MODE_SUBJ, 8'h00);
    push(MODE_RUN, 8'hFF);
    push_case("*", "Zz{");
    push(MODE_SUBJ, 8'hFF);
    push(MODE_RUN, 8'h55);
    // Overflow: one byte past the mask store.
    for (int i = 0; i <= MDEPTH; i++) push(MODE_MASK, 8'h78);
    push(MODE_RUN, 8'h00);
    // Full stores that match literally: longest count.
    for (int i = 0; i < MDEPTH; i++) push(MODE_MASK, 8'(8'h41 + (i % 26)));
    for (int i = 0; i < SDEPTH; i++) push(MODE_SUBJ, 8'(8'h61 + (i % 26)));
    push(MODE_RUN, 8'h00);
    // Subject overflow.
    for (int i = 0; i <= SDEPTH; i++) push(MODE_SUBJ, 8'h20);
    push(MODE_RUN, 8'h00);

    // Random part: mostly well-formed mask/subject pairs, some noise.
    while (pushed < ITEM_TARGET) begin
      pick = $urandom_range(0, 19);
      if (pick == 0) begin
        push(2'($urandom_range(0, 3)), 8'($urandom));
      end else begin
        len_m = $urandom_range(0, 8);
        len_s = $urandom_range(0, 10);
        for (int i = 0; i < len_m; i++) push(MODE_MASK, pick_byte(1));
        for (int i = 0; i < len_s; i++) push(MODE_SUBJ, pick_byte(0));
        push(MODE_RUN, 8'($urandom));
      end
      if (pick == 1) begin
        // One stretch that waits for the core to drain completely.
        wait (pending_items.size() == 0 && !in_valid);
        hold_sender = 1;
        wait (expected_verdicts.size() == 0);
        hold_sender = 0;
      end
    end
    push(MODE_RUN, 8'h00);
    stim_done = 1;
  end

  // Driver: one item at a time, random gap before each.
  int send_gap;
  always @(posedge clk) begin
    int gap;
    if (rst) begin
      in_valid  <= 1'b0;
      mode      <= MODE_MASK;
      char_byte <= 8'h00;
      send_gap  <= 0;
    end else if (in_valid && !in_stall) begin
      predict_item({mode, char_byte});
      if (mode == MODE_RUN) runs_sent++;
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
      // with no gap, load next item straight away
      if (gap == 0 && pending_items.size() != 0 && !hold_sender) begin
        {mode, char_byte} <= pending_items.pop_front();
      end else begin
        in_valid <= 1'b0;
        send_gap <= gap;
      end
    end else if (!in_valid) begin
      if (send_gap > 0) send_gap <= send_gap - 1;
      else if (pending_items.size() != 0 && !hold_sender) begin
        in_valid  <= 1'b1;
        {mode, char_byte} <= pending_items.pop_front();
      end
    end
  end

  // Monitor: random stall per item, compare against oldest expectation.
  int stall_left;
  always @(posedge clk) begin
    verdict_t want;
    if (rst) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_verdicts.size() == 0) begin
          $error("result with nothing expected");
          errors++;
        end else begin
          want = expected_verdicts.pop_front();
          if (matched !== want.matched) begin
            $error("matched: expected %0d, got %0d", want.matched, matched);
            errors++;
          end
          if (literal_count !== want.count) begin
            $error("literal_count: expected %0d, got %0d", want.count, literal_count);
            errors++;
          end
          if (overflow !== want.overflow) begin
            $error("overflow: expected %0d, got %0d", want.overflow, overflow);
            errors++;
          end
          if (want.matched) hits_seen++;
        end
        stall_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
        out_stall  <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_stall  <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Cycle counter and end of run.
  always @(posedge clk) begin
    if (rst) begin
      cycles <= 0;
    end else begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
        $display("timeout: %0d runs issued, %0d results pending", runs_sent,
                 expected_verdicts.size());
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  initial begin
    wait (stim_done);
    wait (pending_items.size() == 0 && !in_valid);
    wait (expected_verdicts.size() == 0);
    repeat (100) @(posedge clk);
    $display("covered %0d match runs (%0d hits) over mask, subject, overflow and noise",
             runs_sent, hits_seen);
    if (errors == 0 && expected_verdicts.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ===== wildcard_mask_matcher_core.f =====
+incdir+src
src/wmm_pkg.sv
src/wmm_ram.sv
src/wmm_dp.sv
src/wmm_ctrl.sv
src/wildcard_mask_matcher_core.sv
bench/tb_wildcard_mask_matcher_core.sv
